@@ src/tapa_pkg.sv @@
// Shared constants for the trie address pool allocator.
`timescale 1ns / 1ps

package tapa_pkg;

  localparam int MAX_HOST_BITS_DEF = 10;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_NETWORK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX  = 2'd1;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_MOVED = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [31:0] NETWORK_RESET = 32'd0;
  localparam logic [4:0]  PREFIX_RESET  = 5'd24;
  localparam int          RESERVED_HOSTS = 3;

endpackage

@@ src/tapa_tree_ram.sv @@
// Single-bit occupancy memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tapa_tree_ram #(
  parameter int ADDR_W = tapa_pkg::MAX_HOST_BITS_DEF + 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/trie_address_pool_allocator.sv @@
// Top level of the trie address pool allocator: sequencer, registers and tree memory.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low, and its result appears on status,
// granted_address and free_count with done high for exactly one cycle; the receiver cannot
// stall it. All work goes through one occupancy memory with one read and one write per cycle,
// one tree level per cycle. An allocate walks down the tree to a free leaf and then updates
// the full marks on the way up; a release of an address in use clears the marks from its leaf
// up to the root; an allocate into a full pool or a release of a free address ends as soon as
// the root or leaf is fetched. After reset and after every register write the block clears all
// 2^(MAX_HOST_BITS+1) memory entries and then marks the three reserved hosts; busy stays high
// during that time, while register writes are still taken.

module trie_address_pool_allocator #(
  parameter int MAX_HOST_BITS = tapa_pkg::MAX_HOST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic [31:0]                      requested_address,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [31:0]                      granted_address,
  output logic [10:0]                      free_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tapa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int AW = MAX_HOST_BITS + 1;
  localparam int HW = $clog2(MAX_HOST_BITS + 1);
  localparam int CW = MAX_HOST_BITS + 1;
  localparam logic [AW-1:0] ROOT = AW'(1);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_RESERVE = 7'b0000010,
    S_IDLE    = 7'b0000100,
    S_FETCH   = 7'b0001000,
    S_WALK    = 7'b0010000,
    S_UP      = 7'b0100000,
    S_RELCLR  = 7'b1000000
  } state_t;

  state_t                   state, state_next;
  logic [AW-1:0]            node, node_next;
  logic                     val, val_next;
  logic [HW-1:0]            lvl, lvl_next;
  logic                     cmd, cmd_next;
  logic [MAX_HOST_BITS-1:0] req, req_next;
  logic [MAX_HOST_BITS-1:0] host, host_next;
  logic [1:0]               rsel, rsel_next;
  logic                     rebuilding, rebuilding_next;
  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            clr_addr, clr_addr_next;
  logic [31:0]              net_addr, net_addr_next;
  logic [4:0]               prefix, prefix_next;
  logic                     done_next;
  logic [1:0]               status_next;
  logic [31:0]              granted_next;

  logic                     we, wdata, rdata;
  logic [AW-1:0]            waddr, raddr;

  logic [5:0]               hdiff;
  logic [HW-1:0]            hbits;
  logic [MAX_HOST_BITS-1:0] mask, req_in, rsv_host;
  logic [AW-1:0]            leaf_in, leaf_req, leaf_rsv, parent, next_node;
  logic                     rb_cur, rb_nxt, side, pval;
  logic [CW-1:0]            count_inc, count_dec;

  tapa_tree_ram #(
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    hdiff = 6'd32 - {1'b0, prefix};
    if (hdiff > 6'(MAX_HOST_BITS)) begin
      hbits = HW'(MAX_HOST_BITS);
    end else if (hdiff < 6'd2) begin
      hbits = HW'(2);
    end else begin
      hbits = HW'(hdiff);
    end
  end

  assign mask      = ~({MAX_HOST_BITS{1'b1}} << hbits);
  assign req_in    = requested_address[MAX_HOST_BITS-1:0] & mask;
  assign leaf_in   = (ROOT << hbits) | AW'(req_in);
  assign leaf_req  = (ROOT << hbits) | AW'(req);
  assign leaf_rsv  = (ROOT << hbits) | AW'(rsv_host);
  assign parent    = node >> 1;
  assign rb_cur    = req[HW'(lvl - HW'(1))];
  assign rb_nxt    = req[HW'(lvl - HW'(2))];
  assign side      = rb_cur ^ rdata;
  assign next_node = {node[AW-2:0], side};
  assign pval      = val & rdata;
  assign count_inc = count + CW'(1);
  assign count_dec = (count != '0) ? count - CW'(1) : count;

  always_comb begin
    case (rsel)
      2'd0:    rsv_host = '0;
      2'd1:    rsv_host = mask;
      default: rsv_host = mask - MAX_HOST_BITS'(1);
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign free_count = 11'(count);

  always_comb begin
    state_next      = state;
    node_next       = node;
    val_next        = val;
    lvl_next        = lvl;
    cmd_next        = cmd;
    req_next        = req;
    host_next       = host;
    rsel_next       = rsel;
    rebuilding_next = rebuilding;
    count_next      = count;
    clr_addr_next   = clr_addr;
    net_addr_next   = net_addr;
    prefix_next     = prefix;
    done_next       = 1'b0;
    status_next     = status;
    granted_next    = granted_address;
    we              = 1'b0;
    waddr           = node;
    wdata           = 1'b0;
    raddr           = ROOT;

    unique case (state)
      S_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = 1'b0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          rsel_next  = 2'd0;
          state_next = S_RESERVE;
        end
      end
      S_RESERVE: begin
        we         = 1'b1;
        waddr      = leaf_rsv;
        wdata      = 1'b1;
        raddr      = leaf_rsv ^ AW'(1);
        node_next  = leaf_rsv;
        val_next   = 1'b1;
        rsel_next  = rsel + 2'd1;
        state_next = S_UP;
      end
      S_IDLE: begin
        raddr = (command == tapa_pkg::CMD_RELEASE) ? leaf_in : ROOT;
        if (start) begin
          cmd_next   = command;
          req_next   = req_in;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (cmd == tapa_pkg::CMD_ALLOC) begin
          if (rdata) begin
            done_next    = 1'b1;
            status_next  = tapa_pkg::STATUS_FULL;
            granted_next = '0;
            state_next   = S_IDLE;
          end else begin
            node_next  = ROOT;
            lvl_next   = hbits;
            raddr      = {ROOT[AW-2:0], req[HW'(hbits - HW'(1))]};
            state_next = S_WALK;
          end
        end else begin
          if (rdata) begin
            node_next  = leaf_req;
            state_next = S_RELCLR;
          end else begin
            done_next    = 1'b1;
            status_next  = tapa_pkg::STATUS_OK;
            granted_next = '0;
            state_next   = S_IDLE;
          end
        end
      end
      S_WALK: begin
        node_next = next_node;
        if (lvl == HW'(1)) begin
          host_next  = next_node[MAX_HOST_BITS-1:0] & mask;
          we         = 1'b1;
          waddr      = next_node;
          wdata      = 1'b1;
          raddr      = next_node ^ AW'(1);
          val_next   = 1'b1;
          state_next = S_UP;
        end else begin
          lvl_next = lvl - HW'(1);
          raddr    = {next_node[AW-2:0], rb_nxt};
        end
      end
      S_UP: begin
        we    = 1'b1;
        waddr = parent;
        wdata = pval;
        if (parent == ROOT) begin
          if (rebuilding) begin
            if (rsel == 2'd3) begin
              rebuilding_next = 1'b0;
              count_next      = CW'({1'b0, mask}) + CW'(1) - CW'(tapa_pkg::RESERVED_HOSTS);
              state_next      = S_IDLE;
            end else begin
              state_next = S_RESERVE;
            end
          end else begin
            count_next   = count_dec;
            done_next    = 1'b1;
            status_next  = (host == req) ? tapa_pkg::STATUS_OK : tapa_pkg::STATUS_MOVED;
            granted_next = (net_addr & ~32'(mask)) | 32'(host);
            state_next   = S_IDLE;
          end
        end else begin
          raddr     = parent ^ AW'(1);
          node_next = parent;
          val_next  = pval;
        end
      end
      S_RELCLR: begin
        we        = 1'b1;
        waddr     = node;
        wdata     = 1'b0;
        node_next = parent;
        if (node == ROOT) begin
          count_next   = count_inc;
          done_next    = 1'b1;
          status_next  = tapa_pkg::STATUS_OK;
          granted_next = '0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        tapa_pkg::REG_NETWORK: begin
          net_addr_next   = cfg_data;
          clr_addr_next   = '0;
          rebuilding_next = 1'b1;
          state_next      = S_CLEAR;
        end
        tapa_pkg::REG_PREFIX: begin
          prefix_next     = cfg_data[4:0];
          clr_addr_next   = '0;
          rebuilding_next = 1'b1;
          state_next      = S_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      rebuilding <= 1'b1;
      rsel       <= 2'd0;
      net_addr   <= tapa_pkg::NETWORK_RESET;
      prefix     <= tapa_pkg::PREFIX_RESET;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      rebuilding <= rebuilding_next;
      rsel       <= rsel_next;
      net_addr   <= net_addr_next;
      prefix     <= prefix_next;
      count      <= count_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    node            <= node_next;
    val             <= val_next;
    lvl             <= lvl_next;
    cmd             <= cmd_next;
    req             <= req_next;
    host            <= host_next;
    status          <= status_next;
    granted_address <= granted_next;
  end

endmodule
